// ===== rtl/sd_card_spi_host_engine_macros.svh =====
// ----------------------------------------------------------------------------
// sd card spi host engine assertion macros
// concurrent assertion helpers, empty in synthesis builds
// ----------------------------------------------------------------------------
`ifndef SD_CARD_SPI_HOST_ENGINE_MACROS_SVH
`define SD_CARD_SPI_HOST_ENGINE_MACROS_SVH
`ifndef SYNTHESIS
`define SDSPI_ASSERT_IMPL(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("sdspi: same-cycle check failed");
`define SDSPI_ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("sdspi: next-cycle check failed");
`else
`define SDSPI_ASSERT_IMPL(label, clk, rst, pre, post)
`define SDSPI_ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

// ===== rtl/sdspi_pkg.sv =====
// ----------------------------------------------------------------------------
// sdspi_pkg
// types, codes and command frame helper for the sd card spi host engine
// ----------------------------------------------------------------------------
package sdspi_pkg;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] sector_address;
    logic [1:0]  half_select;
    logic [7:0]  write_byte;
    logic [7:0]  spi_rx_byte;
  } in_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] tx_byte;
    logic       chip_select;
    logic [7:0] read_byte;
    logic [1:0] status;
    logic [2:0] card_type;
    logic       last_of_run;
  } out_t;

  localparam logic [2:0] CMD_INIT  = 3'd0;
  localparam logic [2:0] CMD_READ  = 3'd1;
  localparam logic [2:0] CMD_WRITE = 3'd2;
  localparam logic [2:0] CMD_LOAD  = 3'd3;
  localparam logic [2:0] CMD_SPI   = 3'd4;

  localparam logic [1:0] KIND_TX   = 2'd0;
  localparam logic [1:0] KIND_DATA = 2'd1;
  localparam logic [1:0] KIND_DONE = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_RW_ERR    = 2'd1;
  localparam logic [1:0] ST_INIT_FAIL = 2'd2;

  localparam logic [2:0] CT_NONE      = 3'd0;
  localparam logic [2:0] CT_MMC       = 3'd1;
  localparam logic [2:0] CT_SD1       = 3'd2;
  localparam logic [2:0] CT_SD2_BYTE  = 3'd3;
  localparam logic [2:0] CT_SD2_BLOCK = 3'd4;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;
  localparam logic [2:0] CFG_RESPONSE_RETRIES  = 3'd0;
  localparam logic [2:0] CFG_SD2_INIT_TRIES    = 3'd1;
  localparam logic [2:0] CFG_V1_INIT_TRIES     = 3'd2;
  localparam logic [2:0] CFG_TOKEN_WAIT        = 3'd3;
  localparam logic [2:0] CFG_BUSY_WAIT         = 3'd4;
  localparam logic [2:0] CFG_DUMMY_CLOCK_BYTES = 3'd5;

  localparam logic [4:0] PH_IDLE    = 5'd0;
  localparam logic [4:0] PH_DUMMY   = 5'd1;
  localparam logic [4:0] PH_CMD0    = 5'd2;
  localparam logic [4:0] PH_CMD8    = 5'd3;
  localparam logic [4:0] PH_R7      = 5'd4;
  localparam logic [4:0] PH_A41V2   = 5'd5;
  localparam logic [4:0] PH_CMD58   = 5'd6;
  localparam logic [4:0] PH_OCR     = 5'd7;
  localparam logic [4:0] PH_PROBE   = 5'd8;
  localparam logic [4:0] PH_V1LOOP  = 5'd9;
  localparam logic [4:0] PH_CMD16   = 5'd10;
  localparam logic [4:0] PH_CMD17   = 5'd11;
  localparam logic [4:0] PH_TOKEN   = 5'd12;
  localparam logic [4:0] PH_DATA    = 5'd13;
  localparam logic [4:0] PH_CRC     = 5'd14;
  localparam logic [4:0] PH_CMD24   = 5'd15;
  localparam logic [4:0] PH_WGAP    = 5'd16;
  localparam logic [4:0] PH_WTOK    = 5'd17;
  localparam logic [4:0] PH_WDATA   = 5'd18;
  localparam logic [4:0] PH_WCRC    = 5'd19;
  localparam logic [4:0] PH_WRESP   = 5'd20;
  localparam logic [4:0] PH_WBUSY   = 5'd21;
  localparam logic [4:0] PH_RELEASE = 5'd22;

  localparam logic [5:0] SD_CMD0  = 6'd0;
  localparam logic [5:0] SD_CMD1  = 6'd1;
  localparam logic [5:0] SD_CMD8  = 6'd8;
  localparam logic [5:0] SD_CMD16 = 6'd16;
  localparam logic [5:0] SD_CMD17 = 6'd17;
  localparam logic [5:0] SD_CMD24 = 6'd24;
  localparam logic [5:0] SD_CMD41 = 6'd41;
  localparam logic [5:0] SD_CMD55 = 6'd55;
  localparam logic [5:0] SD_CMD58 = 6'd58;

  localparam logic [7:0]  CRC_CMD0    = 8'h95;
  localparam logic [7:0]  CRC_CMD8    = 8'h87;
  localparam logic [7:0]  CRC_DEFAULT = 8'h01;
  localparam logic [31:0] CMD8_ARG    = 32'h0000_01AA;
  localparam logic [31:0] ACMD41_HCS  = 32'h4000_0000;
  localparam logic [7:0]  IDLE_BYTE   = 8'hFF;
  localparam logic [7:0]  TOKEN_START = 8'hFE;
  localparam logic [7:0]  DRESP_MASK  = 8'h1F;
  localparam logic [7:0]  DRESP_OK    = 8'h05;
  localparam logic [7:0]  OCR_CCS     = 8'h40;
  localparam logic [7:0]  CHECK_ECHO  = 8'hAA;
  localparam logic [7:0]  VHS_ECHO    = 8'h01;

  function automatic logic [47:0] make_frame(input logic [5:0] idx, input logic [31:0] arg);
    logic [7:0] crc;
    crc = (idx == SD_CMD0) ? CRC_CMD0 : ((idx == SD_CMD8) ? CRC_CMD8 : CRC_DEFAULT);
    return {2'b01, idx, arg, crc};
  endfunction

endpackage

// ===== rtl/sdspi_ram.sv =====
// ----------------------------------------------------------------------------
// sdspi_ram
// simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module sdspi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/sd_card_spi_host_engine.sv =====
// ----------------------------------------------------------------------------
// sd_card_spi_host_engine
// host side of the sd/mmc spi protocol: init, sector read and sector write
// ----------------------------------------------------------------------------
// Every accepted transaction is decoded in the cycle it arrives and its results
// land in a four-entry output queue, so in_ready depends only on queue fill
// (high while it holds two entries or fewer) and a new transaction can enter on
// every clock while the queue has room. Most transactions give one result; a
// received data byte inside the read window gives two, so there the output side
// sets the sustained rate. Write data comes from a sector buffer ram with
// registered read that is prefetched one byte ahead. The buffer has no clear
// after reset; load the sector before issuing a write.
`include "sd_card_spi_host_engine_macros.svh"

module sd_card_spi_host_engine #(
  parameter int SECTOR_BYTES = 512
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  sdspi_pkg::in_t                      in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output sdspi_pkg::out_t                     out_data,
  input  logic                                cfg_write,
  input  logic [sdspi_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sdspi_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int AW   = $clog2(SECTOR_BYTES);
  localparam int BC_W = AW + 1;
  localparam int HALF = SECTOR_BYTES / 2;

  // configuration
  logic [7:0]  response_retries;
  logic [15:0] sd2_init_tries;
  logic [15:0] v1_init_tries;
  logic [15:0] token_wait;
  logic [17:0] busy_wait;
  logic [7:0]  dummy_clock_bytes;

  // engine state
  logic [4:0]      phase, phase_next;
  logic [BC_W-1:0] byte_count, byte_count_next;
  logic [17:0]     poll_count, poll_count_next;
  logic [15:0]     try_count, try_count_next;
  logic [2:0]      card_kind, card_kind_next;
  logic [3:0][7:0] ocr_bytes, ocr_bytes_next;
  logic [47:0]     command_frame, command_frame_next;
  logic [47:0]     pend_frame, pend_frame_next;
  logic            app_pending, app_pending_next;
  logic            cmd_active, cmd_active_next;
  logic [3:0]      cmd_stage, cmd_stage_next;
  logic [2:0]      new_kind, new_kind_next;
  logic [1:0]      done_status, done_status_next;
  logic [1:0]      read_half, read_half_next;
  logic [AW-1:0]   fill_pointer, fill_pointer_next;

  logic            in_fire;
  logic            release_fire;
  logic [7:0]      rx;
  logic [17:0]     pc_inc;
  logic [BC_W-1:0] bc_inc;
  logic [8:0]      rr_lim;
  logic [16:0]     tw_lim;
  logic [31:0]     card_addr;

  logic            do_start, st_app, do_begin, do_retry, do_loop, do_fin, do_rel, res_go;
  logic [5:0]      st_idx;
  logic [31:0]     st_arg;
  logic [4:0]      begin_ph;
  logic [15:0]     begin_tries;
  logic [2:0]      fin_ty;
  logic [1:0]      rel_st;
  logic            emit, push_data, push_done, ram_we;
  logic [7:0]      tx, ram_rdata;
  logic            cs;
  logic [AW-1:0]   ram_raddr;

  // output queue
  localparam int QD = 4;
  sdspi_pkg::out_t q_mem [QD];
  logic [1:0]      q_head, q_tail;
  logic [2:0]      q_count;
  sdspi_pkg::out_t item0, item1;
  logic [1:0]      nres;
  logic            pop;

  assign in_fire   = in_valid && in_ready;
  assign in_ready  = (q_count <= 3'd2);
  assign out_valid = (q_count != 3'd0);
  assign out_data  = q_mem[q_head];
  assign pop       = out_valid && out_ready;
  assign rx        = in_data.spi_rx_byte;
  assign pc_inc    = poll_count + 18'd1;
  assign bc_inc    = byte_count + BC_W'(1);
  assign rr_lim    = (response_retries == 8'd0) ? 9'd256 : {1'b0, response_retries};
  assign tw_lim    = (token_wait == 16'd0) ? 17'h10000 : {1'b0, token_wait};
  assign card_addr = (card_kind == sdspi_pkg::CT_SD2_BLOCK) ? in_data.sector_address :
                     32'(in_data.sector_address * 32'(SECTOR_BYTES));
  assign release_fire = in_fire && (in_data.cmd == sdspi_pkg::CMD_SPI) &&
                        (phase == sdspi_pkg::PH_RELEASE);

  always_comb begin
    phase_next         = phase;
    byte_count_next    = byte_count;
    poll_count_next    = poll_count;
    try_count_next     = try_count;
    card_kind_next     = card_kind;
    ocr_bytes_next     = ocr_bytes;
    command_frame_next = command_frame;
    pend_frame_next    = pend_frame;
    app_pending_next   = app_pending;
    cmd_active_next    = cmd_active;
    cmd_stage_next     = cmd_stage;
    new_kind_next      = new_kind;
    done_status_next   = done_status;
    read_half_next     = read_half;
    fill_pointer_next  = fill_pointer;
    do_start    = 1'b0;
    st_app      = 1'b0;
    st_idx      = sdspi_pkg::SD_CMD0;
    st_arg      = '0;
    do_begin    = 1'b0;
    begin_ph    = sdspi_pkg::PH_IDLE;
    begin_tries = '0;
    do_retry    = 1'b0;
    do_loop     = 1'b0;
    do_fin      = 1'b0;
    fin_ty      = sdspi_pkg::CT_NONE;
    do_rel      = 1'b0;
    rel_st      = sdspi_pkg::ST_OK;
    res_go      = 1'b0;
    emit        = 1'b0;
    push_data   = 1'b0;
    push_done   = 1'b0;
    ram_we      = 1'b0;

    if (in_fire) begin
      case (in_data.cmd)
        sdspi_pkg::CMD_INIT, sdspi_pkg::CMD_READ, sdspi_pkg::CMD_WRITE: begin
          if (phase == sdspi_pkg::PH_IDLE) begin
            emit = 1'b1;
            if (in_data.cmd == sdspi_pkg::CMD_INIT) begin
              phase_next      = sdspi_pkg::PH_DUMMY;
              byte_count_next = '0;
              new_kind_next   = sdspi_pkg::CT_NONE;
              if (dummy_clock_bytes == 8'd0) begin
                phase_next = sdspi_pkg::PH_CMD0;
                do_start   = 1'b1;
                st_idx     = sdspi_pkg::SD_CMD0;
              end
            end else if (in_data.cmd == sdspi_pkg::CMD_READ) begin
              read_half_next = in_data.half_select;
              phase_next     = sdspi_pkg::PH_CMD17;
              do_start       = 1'b1;
              st_idx         = sdspi_pkg::SD_CMD17;
              st_arg         = card_addr;
            end else begin
              fill_pointer_next = '0;
              phase_next        = sdspi_pkg::PH_CMD24;
              do_start          = 1'b1;
              st_idx            = sdspi_pkg::SD_CMD24;
              st_arg            = card_addr;
            end
          end
        end
        sdspi_pkg::CMD_LOAD: begin
          if (phase == sdspi_pkg::PH_IDLE) begin
            ram_we            = 1'b1;
            fill_pointer_next = (fill_pointer == AW'(SECTOR_BYTES - 1)) ? '0 :
                                fill_pointer + AW'(1);
          end
        end
        sdspi_pkg::CMD_SPI: begin
          if (phase == sdspi_pkg::PH_RELEASE) begin
            phase_next = sdspi_pkg::PH_IDLE;
            push_done  = 1'b1;
          end else if (phase != sdspi_pkg::PH_IDLE) begin
            emit = 1'b1;
            if (cmd_active) begin
              if (cmd_stage < 4'd8) begin
                cmd_stage_next = cmd_stage + 4'd1;
                if (cmd_stage_next == 4'd8) begin
                  poll_count_next = '0;
                end
              end else begin
                poll_count_next = pc_inc;
                if (!(rx[7] && (pc_inc < 18'(rr_lim)))) begin
                  res_go = 1'b1;
                  if (app_pending) begin
                    app_pending_next = 1'b0;
                    if (rx <= 8'd1) begin
                      command_frame_next = pend_frame;
                      cmd_stage_next     = '0;
                      res_go             = 1'b0;
                    end
                  end
                end
                if (res_go) begin
                  cmd_active_next = 1'b0;
                  case (phase)
                    sdspi_pkg::PH_CMD0: begin
                      if (rx == 8'd1) begin
                        phase_next = sdspi_pkg::PH_CMD8;
                        do_start   = 1'b1;
                        st_idx     = sdspi_pkg::SD_CMD8;
                        st_arg     = sdspi_pkg::CMD8_ARG;
                      end else begin
                        do_fin = 1'b1;
                      end
                    end
                    sdspi_pkg::PH_CMD8: begin
                      if (rx == 8'd1) begin
                        phase_next      = sdspi_pkg::PH_R7;
                        byte_count_next = '0;
                      end else begin
                        phase_next = sdspi_pkg::PH_PROBE;
                        do_start   = 1'b1;
                        st_idx     = sdspi_pkg::SD_CMD41;
                        st_app     = 1'b1;
                      end
                    end
                    sdspi_pkg::PH_A41V2: begin
                      if (rx == 8'd0) begin
                        phase_next = sdspi_pkg::PH_CMD58;
                        do_start   = 1'b1;
                        st_idx     = sdspi_pkg::SD_CMD58;
                      end else begin
                        do_retry = 1'b1;
                      end
                    end
                    sdspi_pkg::PH_CMD58: begin
                      if (rx == 8'd0) begin
                        phase_next      = sdspi_pkg::PH_OCR;
                        byte_count_next = '0;
                      end else begin
                        do_fin = 1'b1;
                      end
                    end
                    sdspi_pkg::PH_PROBE: begin
                      new_kind_next = (rx <= 8'd1) ? sdspi_pkg::CT_SD1 : sdspi_pkg::CT_MMC;
                      do_begin      = 1'b1;
                      begin_ph      = sdspi_pkg::PH_V1LOOP;
                      begin_tries   = v1_init_tries;
                    end
                    sdspi_pkg::PH_V1LOOP: begin
                      if (rx == 8'd0) begin
                        phase_next = sdspi_pkg::PH_CMD16;
                        do_start   = 1'b1;
                        st_idx     = sdspi_pkg::SD_CMD16;
                        st_arg     = 32'(SECTOR_BYTES);
                      end else begin
                        do_retry = 1'b1;
                      end
                    end
                    sdspi_pkg::PH_CMD16: begin
                      do_fin = 1'b1;
                      fin_ty = (rx == 8'd0) ? new_kind : sdspi_pkg::CT_NONE;
                    end
                    sdspi_pkg::PH_CMD17: begin
                      if (rx == 8'd0) begin
                        phase_next      = sdspi_pkg::PH_TOKEN;
                        poll_count_next = '0;
                      end else begin
                        do_rel = 1'b1;
                        rel_st = sdspi_pkg::ST_RW_ERR;
                      end
                    end
                    sdspi_pkg::PH_CMD24: begin
                      if (rx == 8'd0) begin
                        phase_next = sdspi_pkg::PH_WGAP;
                      end else begin
                        do_rel = 1'b1;
                        rel_st = sdspi_pkg::ST_RW_ERR;
                      end
                    end
                    default: begin
                      do_rel = 1'b1;
                      rel_st = sdspi_pkg::ST_RW_ERR;
                    end
                  endcase
                end
              end
            end else begin
              case (phase)
                sdspi_pkg::PH_DUMMY: begin
                  byte_count_next = bc_inc;
                  if (bc_inc >= BC_W'(dummy_clock_bytes)) begin
                    phase_next = sdspi_pkg::PH_CMD0;
                    do_start   = 1'b1;
                    st_idx     = sdspi_pkg::SD_CMD0;
                  end
                end
                sdspi_pkg::PH_R7, sdspi_pkg::PH_OCR: begin
                  ocr_bytes_next[byte_count[1:0]] = rx;
                  byte_count_next                 = bc_inc;
                  if (bc_inc >= BC_W'(4)) begin
                    if (phase == sdspi_pkg::PH_OCR) begin
                      do_fin = 1'b1;
                      fin_ty = ((ocr_bytes_next[0] & sdspi_pkg::OCR_CCS) != 8'd0) ?
                               sdspi_pkg::CT_SD2_BLOCK : sdspi_pkg::CT_SD2_BYTE;
                    end else if (ocr_bytes_next[2] == sdspi_pkg::VHS_ECHO &&
                                 ocr_bytes_next[3] == sdspi_pkg::CHECK_ECHO) begin
                      do_begin    = 1'b1;
                      begin_ph    = sdspi_pkg::PH_A41V2;
                      begin_tries = sd2_init_tries;
                    end else begin
                      do_fin = 1'b1;
                    end
                  end
                end
                sdspi_pkg::PH_TOKEN: begin
                  poll_count_next = pc_inc;
                  if (rx != sdspi_pkg::IDLE_BYTE) begin
                    if (rx == sdspi_pkg::TOKEN_START) begin
                      phase_next      = sdspi_pkg::PH_DATA;
                      byte_count_next = '0;
                    end else begin
                      do_rel = 1'b1;
                      rel_st = sdspi_pkg::ST_RW_ERR;
                    end
                  end else if (pc_inc >= 18'(tw_lim)) begin
                    do_rel = 1'b1;
                    rel_st = sdspi_pkg::ST_RW_ERR;
                  end
                end
                sdspi_pkg::PH_DATA: begin
                  push_data = (read_half == 2'd1) ? (byte_count < BC_W'(HALF)) :
                              (read_half == 2'd2) ? (byte_count >= BC_W'(HALF)) : 1'b1;
                  byte_count_next = bc_inc;
                  if (bc_inc >= BC_W'(SECTOR_BYTES)) begin
                    phase_next      = sdspi_pkg::PH_CRC;
                    byte_count_next = '0;
                  end
                end
                sdspi_pkg::PH_CRC, sdspi_pkg::PH_WCRC: begin
                  byte_count_next = bc_inc;
                  if (bc_inc >= BC_W'(2)) begin
                    if (phase == sdspi_pkg::PH_CRC) begin
                      do_rel = 1'b1;
                    end else begin
                      phase_next = sdspi_pkg::PH_WRESP;
                    end
                  end
                end
                sdspi_pkg::PH_WGAP: begin
                  phase_next = sdspi_pkg::PH_WTOK;
                end
                sdspi_pkg::PH_WTOK: begin
                  phase_next      = sdspi_pkg::PH_WDATA;
                  byte_count_next = '0;
                end
                sdspi_pkg::PH_WDATA: begin
                  byte_count_next = bc_inc;
                  if (bc_inc >= BC_W'(SECTOR_BYTES)) begin
                    phase_next      = sdspi_pkg::PH_WCRC;
                    byte_count_next = '0;
                  end
                end
                sdspi_pkg::PH_WRESP: begin
                  if ((rx & sdspi_pkg::DRESP_MASK) == sdspi_pkg::DRESP_OK) begin
                    phase_next      = sdspi_pkg::PH_WBUSY;
                    poll_count_next = busy_wait;
                  end else begin
                    do_rel = 1'b1;
                    rel_st = sdspi_pkg::ST_RW_ERR;
                  end
                end
                sdspi_pkg::PH_WBUSY: begin
                  if (rx == sdspi_pkg::IDLE_BYTE) begin
                    do_rel = 1'b1;
                    rel_st = (poll_count != 18'd0) ? sdspi_pkg::ST_OK : sdspi_pkg::ST_RW_ERR;
                  end else if (poll_count == 18'd0) begin
                    do_rel = 1'b1;
                    rel_st = sdspi_pkg::ST_RW_ERR;
                  end else begin
                    poll_count_next = poll_count - 18'd1;
                  end
                end
                default: begin
                  phase_next = sdspi_pkg::PH_IDLE;
                end
              endcase
            end
          end
        end
        default: ;
      endcase
    end

    // init loop bookkeeping, completion and command launch
    if (do_begin) begin
      phase_next     = begin_ph;
      try_count_next = begin_tries;
      if (begin_tries == 16'd0) begin
        do_fin = 1'b1;
        fin_ty = sdspi_pkg::CT_NONE;
      end else begin
        do_loop = 1'b1;
      end
    end
    if (do_retry) begin
      try_count_next = try_count - 16'd1;
      if (try_count_next == 16'd0) begin
        do_fin = 1'b1;
        fin_ty = sdspi_pkg::CT_NONE;
      end else begin
        do_loop = 1'b1;
      end
    end
    if (do_loop) begin
      do_start = 1'b1;
      if (phase_next == sdspi_pkg::PH_A41V2) begin
        st_idx = sdspi_pkg::SD_CMD41;
        st_arg = sdspi_pkg::ACMD41_HCS;
        st_app = 1'b1;
      end else if (new_kind_next == sdspi_pkg::CT_SD1) begin
        st_idx = sdspi_pkg::SD_CMD41;
        st_app = 1'b1;
      end else begin
        st_idx = sdspi_pkg::SD_CMD1;
      end
    end
    if (do_fin) begin
      card_kind_next = fin_ty;
      do_rel         = 1'b1;
      rel_st         = (fin_ty != sdspi_pkg::CT_NONE) ? sdspi_pkg::ST_OK :
                       sdspi_pkg::ST_INIT_FAIL;
    end
    if (do_rel) begin
      done_status_next = rel_st;
      phase_next       = sdspi_pkg::PH_RELEASE;
    end
    if (do_start) begin
      if (st_app) begin
        pend_frame_next    = sdspi_pkg::make_frame(st_idx, st_arg);
        command_frame_next = sdspi_pkg::make_frame(sdspi_pkg::SD_CMD55, 32'd0);
        app_pending_next   = 1'b1;
      end else begin
        command_frame_next = sdspi_pkg::make_frame(st_idx, st_arg);
        app_pending_next   = 1'b0;
      end
      cmd_active_next = 1'b1;
      cmd_stage_next  = '0;
      poll_count_next = '0;
    end

    // next byte on the link
    tx = sdspi_pkg::IDLE_BYTE;
    cs = 1'b1;
    if (cmd_active_next) begin
      case (cmd_stage_next)
        4'd0:    cs = 1'b0;
        4'd2:    tx = command_frame_next[47:40];
        4'd3:    tx = command_frame_next[39:32];
        4'd4:    tx = command_frame_next[31:24];
        4'd5:    tx = command_frame_next[23:16];
        4'd6:    tx = command_frame_next[15:8];
        4'd7:    tx = command_frame_next[7:0];
        default: tx = sdspi_pkg::IDLE_BYTE;
      endcase
    end else if (phase_next == sdspi_pkg::PH_DUMMY || phase_next == sdspi_pkg::PH_RELEASE) begin
      cs = 1'b0;
    end else if (phase_next == sdspi_pkg::PH_WTOK) begin
      tx = sdspi_pkg::TOKEN_START;
    end else if (phase_next == sdspi_pkg::PH_WDATA) begin
      tx = ram_rdata;
    end else if (phase_next == sdspi_pkg::PH_WCRC) begin
      tx = 8'd0;
    end

    // prefetch the sector byte for the next write data exchange
    ram_raddr = (phase_next == sdspi_pkg::PH_WDATA) ? AW'(byte_count_next + BC_W'(1)) : '0;
  end

  always_comb begin
    item0 = '0;
    item1 = '0;
    nres  = 2'd0;
    if (push_done) begin
      item0.kind        = sdspi_pkg::KIND_DONE;
      item0.status      = done_status;
      item0.card_type   = card_kind;
      item0.last_of_run = 1'b1;
      nres              = 2'd1;
    end else if (push_data) begin
      item0.kind        = sdspi_pkg::KIND_DATA;
      item0.read_byte   = rx;
      item1.kind        = sdspi_pkg::KIND_TX;
      item1.tx_byte     = tx;
      item1.chip_select = cs;
      item1.last_of_run = 1'b1;
      nres              = 2'd2;
    end else if (emit) begin
      item0.kind        = sdspi_pkg::KIND_TX;
      item0.tx_byte     = tx;
      item0.chip_select = cs;
      item0.last_of_run = 1'b1;
      nres              = 2'd1;
    end
  end

  sdspi_ram #(
    .WIDTH(8),
    .DEPTH(SECTOR_BYTES)
  ) u_sector_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(fill_pointer),
    .wdata(in_data.write_byte),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      response_retries  <= 8'd10;
      sd2_init_tries    <= 16'd12000;
      v1_init_tries     <= 16'd25000;
      token_wait        <= 16'd30000;
      busy_wait         <= 18'd128000;
      dummy_clock_bytes <= 8'd15;
    end else if (cfg_write) begin
      case (cfg_index)
        sdspi_pkg::CFG_RESPONSE_RETRIES:  response_retries  <= cfg_data[7:0];
        sdspi_pkg::CFG_SD2_INIT_TRIES:    sd2_init_tries    <= cfg_data[15:0];
        sdspi_pkg::CFG_V1_INIT_TRIES:     v1_init_tries     <= cfg_data[15:0];
        sdspi_pkg::CFG_TOKEN_WAIT:        token_wait        <= cfg_data[15:0];
        sdspi_pkg::CFG_BUSY_WAIT:         busy_wait         <= cfg_data[17:0];
        sdspi_pkg::CFG_DUMMY_CLOCK_BYTES: dummy_clock_bytes <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= sdspi_pkg::PH_IDLE;
      byte_count   <= '0;
      poll_count   <= '0;
      try_count    <= '0;
      card_kind    <= sdspi_pkg::CT_NONE;
      app_pending  <= 1'b0;
      cmd_active   <= 1'b0;
      cmd_stage    <= '0;
      new_kind     <= sdspi_pkg::CT_NONE;
      done_status  <= sdspi_pkg::ST_OK;
      read_half    <= '0;
      fill_pointer <= '0;
      q_head       <= '0;
      q_tail       <= '0;
      q_count      <= '0;
    end else begin
      phase        <= phase_next;
      byte_count   <= byte_count_next;
      poll_count   <= poll_count_next;
      try_count    <= try_count_next;
      card_kind    <= card_kind_next;
      app_pending  <= app_pending_next;
      cmd_active   <= cmd_active_next;
      cmd_stage    <= cmd_stage_next;
      new_kind     <= new_kind_next;
      done_status  <= done_status_next;
      read_half    <= read_half_next;
      fill_pointer <= fill_pointer_next;
      q_head       <= q_head + {1'b0, pop};
      q_tail       <= q_tail + nres;
      q_count      <= q_count + {1'b0, nres} - {2'b00, pop};
    end
  end

  always_ff @(posedge clk) begin
    ocr_bytes     <= ocr_bytes_next;
    command_frame <= command_frame_next;
    pend_frame    <= pend_frame_next;
    if (nres != 2'd0) begin
      q_mem[q_tail] <= item0;
    end
    if (nres == 2'd2) begin
      q_mem[q_tail + 2'd1] <= item1;
    end
  end

`SDSPI_ASSERT_IMPL(a_queue_bound, clk, rst, 1'b1, q_count <= 3'd4)
`SDSPI_ASSERT_IMPL(a_idle_no_cmd, clk, rst, phase == sdspi_pkg::PH_IDLE, !cmd_active)
`SDSPI_ASSERT_NEXT(a_release_ends, clk, rst, release_fire, phase == sdspi_pkg::PH_IDLE)

endmodule

// ===== sim/tb_sd_card_spi_host_engine.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sd_card_spi_host_engine
// self-checking bench: a card responder builds protocol-shaped byte streams
// (init, read, write) with random content and noise, a behavioral engine
// predicts every result and the monitor compares them field by field
// ----------------------------------------------------------------------------
module tb_sd_card_spi_host_engine;

  localparam int NBYTES = 512;
  localparam int GEN = 0;
  localparam int CHK = 1;
  localparam int STALL_LIMIT = 20000;
  localparam int IW = sdspi_pkg::CFG_IDX_W;
  localparam int DW = sdspi_pkg::CFG_DATA_W;

  typedef struct {
    logic [4:0]  phase;
    int unsigned byte_count;
    int unsigned poll_count;
    logic [15:0] try_count;
    logic [2:0]  card_kind;
    logic [7:0]  ocr[4];
    logic [47:0] frame;
    logic [47:0] pend_frame;
    bit          app_pend;
    int unsigned fill;
    logic [31:0] addr;
    logic [7:0]  store[NBYTES];
    bit          cmd_active;
    int unsigned cmd_stage;
    logic [2:0]  new_kind;
    logic [1:0]  done_st;
    logic [1:0]  half;
    int unsigned cfg[6];
  } engine_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  sdspi_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_ready = 0;
  sdspi_pkg::out_t out_data;
  logic cfg_write = 0;
  logic [IW-1:0] cfg_index = '0;
  logic [DW-1:0] cfg_data = '0;

  engine_t eng[2];
  sdspi_pkg::out_t step_res[$];
  sdspi_pkg::out_t expected_q[$];
  sdspi_pkg::in_t pending[$];
  int errors = 0;
  int send_idle = 23;
  int recv_idle = 47;
  int n_out = 0;
  int hold_at = 32'h7fff_ffff;
  int hold_left = 0;
  bit held = 0;
  int stall = 0;
  int n_items = 0;
  int seg_end = 0;

  sd_card_spi_host_engine dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------- behavioral engine ----------------
  function automatic void add_res(logic [1:0] kind, logic [7:0] tx, logic cs,
                                  logic [7:0] rd, logic [1:0] st, logic [2:0] ct);
    sdspi_pkg::out_t o;
    o.kind = kind; o.tx_byte = tx; o.chip_select = cs; o.read_byte = rd;
    o.status = st; o.card_type = ct; o.last_of_run = 1'b0;
    step_res.push_back(o);
  endfunction

  function automatic logic [47:0] frame_of(logic [5:0] idx, logic [31:0] arg);
    logic [7:0] crc;
    crc = (idx == sdspi_pkg::SD_CMD0) ? sdspi_pkg::CRC_CMD0 :
          (idx == sdspi_pkg::SD_CMD8) ? sdspi_pkg::CRC_CMD8 : sdspi_pkg::CRC_DEFAULT;
    return {2'b01, idx, arg, crc};
  endfunction

  function automatic void start_cmd(int k, logic [5:0] idx, logic [31:0] arg, bit app);
    if (app) begin
      eng[k].pend_frame = frame_of(idx, arg);
      eng[k].frame = frame_of(sdspi_pkg::SD_CMD55, 32'd0);
      eng[k].app_pend = 1;
    end else begin
      eng[k].frame = frame_of(idx, arg);
      eng[k].app_pend = 0;
    end
    eng[k].cmd_active = 1;
    eng[k].cmd_stage = 0;
    eng[k].poll_count = 0;
  endfunction

  function automatic void go_release(int k, logic [1:0] st);
    eng[k].done_st = st;
    eng[k].phase = sdspi_pkg::PH_RELEASE;
  endfunction

  function automatic void finish_init(int k, logic [2:0] ty);
    eng[k].card_kind = ty;
    go_release(k, (ty != sdspi_pkg::CT_NONE) ? sdspi_pkg::ST_OK : sdspi_pkg::ST_INIT_FAIL);
  endfunction

  function automatic void send_loop(int k);
    if (eng[k].phase == sdspi_pkg::PH_A41V2)
      start_cmd(k, sdspi_pkg::SD_CMD41, sdspi_pkg::ACMD41_HCS, 1);
    else if (eng[k].new_kind == sdspi_pkg::CT_SD1) start_cmd(k, sdspi_pkg::SD_CMD41, 32'd0, 1);
    else start_cmd(k, sdspi_pkg::SD_CMD1, 32'd0, 0);
  endfunction

  function automatic void begin_loop(int k, logic [4:0] ph, logic [15:0] tries);
    eng[k].phase = ph;
    eng[k].try_count = tries;
    if (tries == 0) finish_init(k, sdspi_pkg::CT_NONE);
    else send_loop(k);
  endfunction

  function automatic void retry_loop(int k);
    eng[k].try_count = eng[k].try_count - 16'd1;
    if (eng[k].try_count == 0) finish_init(k, sdspi_pkg::CT_NONE);
    else send_loop(k);
  endfunction

  function automatic logic [31:0] card_addr(int k, logic [31:0] s);
    if (eng[k].card_kind == sdspi_pkg::CT_SD2_BLOCK) return s;
    return 32'(s * NBYTES);
  endfunction

  function automatic void on_result(int k, logic [7:0] r);
    case (eng[k].phase)
      sdspi_pkg::PH_CMD0: begin
        if (r == 1) begin
          eng[k].phase = sdspi_pkg::PH_CMD8;
          start_cmd(k, sdspi_pkg::SD_CMD8, sdspi_pkg::CMD8_ARG, 0);
        end else finish_init(k, sdspi_pkg::CT_NONE);
      end
      sdspi_pkg::PH_CMD8: begin
        if (r == 1) begin
          eng[k].phase = sdspi_pkg::PH_R7;
          eng[k].byte_count = 0;
        end else begin
          eng[k].phase = sdspi_pkg::PH_PROBE;
          start_cmd(k, sdspi_pkg::SD_CMD41, 32'd0, 1);
        end
      end
      sdspi_pkg::PH_A41V2: begin
        if (r == 0) begin
          eng[k].phase = sdspi_pkg::PH_CMD58;
          start_cmd(k, sdspi_pkg::SD_CMD58, 32'd0, 0);
        end else retry_loop(k);
      end
      sdspi_pkg::PH_CMD58: begin
        if (r == 0) begin
          eng[k].phase = sdspi_pkg::PH_OCR;
          eng[k].byte_count = 0;
        end else finish_init(k, sdspi_pkg::CT_NONE);
      end
      sdspi_pkg::PH_PROBE: begin
        eng[k].new_kind = (r <= 1) ? sdspi_pkg::CT_SD1 : sdspi_pkg::CT_MMC;
        begin_loop(k, sdspi_pkg::PH_V1LOOP,
                   16'(eng[k].cfg[sdspi_pkg::CFG_V1_INIT_TRIES]));
      end
      sdspi_pkg::PH_V1LOOP: begin
        if (r == 0) begin
          eng[k].phase = sdspi_pkg::PH_CMD16;
          start_cmd(k, sdspi_pkg::SD_CMD16, NBYTES, 0);
        end else retry_loop(k);
      end
      sdspi_pkg::PH_CMD16:
        finish_init(k, (r == 0) ? eng[k].new_kind : sdspi_pkg::CT_NONE);
      sdspi_pkg::PH_CMD17: begin
        if (r == 0) begin
          eng[k].phase = sdspi_pkg::PH_TOKEN;
          eng[k].poll_count = 0;
        end else go_release(k, sdspi_pkg::ST_RW_ERR);
      end
      sdspi_pkg::PH_CMD24: begin
        if (r == 0) eng[k].phase = sdspi_pkg::PH_WGAP;
        else go_release(k, sdspi_pkg::ST_RW_ERR);
      end
      default: go_release(k, sdspi_pkg::ST_RW_ERR);
    endcase
  endfunction

  function automatic void cmd_rx(int k, logic [7:0] rx);
    int unsigned lim;
    if (eng[k].cmd_stage < 8) begin
      eng[k].cmd_stage++;
      if (eng[k].cmd_stage == 8) eng[k].poll_count = 0;
      return;
    end
    eng[k].poll_count++;
    lim = eng[k].cfg[sdspi_pkg::CFG_RESPONSE_RETRIES] ?
          eng[k].cfg[sdspi_pkg::CFG_RESPONSE_RETRIES] : 256;
    if (rx[7] && eng[k].poll_count < lim) return;
    if (eng[k].app_pend) begin
      eng[k].app_pend = 0;
      if (rx <= 1) begin
        eng[k].frame = eng[k].pend_frame;
        eng[k].cmd_stage = 0;
        return;
      end
    end
    eng[k].cmd_active = 0;
    on_result(k, rx);
  endfunction

  function automatic void phase_rx(int k, logic [7:0] rx);
    int unsigned lim;
    case (eng[k].phase)
      sdspi_pkg::PH_DUMMY: begin
        eng[k].byte_count++;
        if (eng[k].byte_count >= eng[k].cfg[sdspi_pkg::CFG_DUMMY_CLOCK_BYTES]) begin
          eng[k].phase = sdspi_pkg::PH_CMD0;
          start_cmd(k, sdspi_pkg::SD_CMD0, 32'd0, 0);
        end
      end
      sdspi_pkg::PH_R7, sdspi_pkg::PH_OCR: begin
        eng[k].ocr[eng[k].byte_count % 4] = rx;
        eng[k].byte_count++;
        if (eng[k].byte_count >= 4) begin
          if (eng[k].phase == sdspi_pkg::PH_OCR)
            finish_init(k, (eng[k].ocr[0] & sdspi_pkg::OCR_CCS) ?
                           sdspi_pkg::CT_SD2_BLOCK : sdspi_pkg::CT_SD2_BYTE);
          else if (eng[k].ocr[2] == sdspi_pkg::VHS_ECHO &&
                   eng[k].ocr[3] == sdspi_pkg::CHECK_ECHO)
            begin_loop(k, sdspi_pkg::PH_A41V2,
                       16'(eng[k].cfg[sdspi_pkg::CFG_SD2_INIT_TRIES]));
          else finish_init(k, sdspi_pkg::CT_NONE);
        end
      end
      sdspi_pkg::PH_TOKEN: begin
        eng[k].poll_count++;
        lim = eng[k].cfg[sdspi_pkg::CFG_TOKEN_WAIT] ?
              eng[k].cfg[sdspi_pkg::CFG_TOKEN_WAIT] : 65536;
        if (rx != sdspi_pkg::IDLE_BYTE) begin
          if (rx == sdspi_pkg::TOKEN_START) begin
            eng[k].phase = sdspi_pkg::PH_DATA;
            eng[k].byte_count = 0;
          end else go_release(k, sdspi_pkg::ST_RW_ERR);
        end else if (eng[k].poll_count >= lim) go_release(k, sdspi_pkg::ST_RW_ERR);
      end
      sdspi_pkg::PH_DATA: begin
        if ((eng[k].half == 1 && eng[k].byte_count < NBYTES / 2) ||
            (eng[k].half == 2 && eng[k].byte_count >= NBYTES / 2) ||
            eng[k].half == 0 || eng[k].half == 3)
          add_res(sdspi_pkg::KIND_DATA, 8'd0, 1'b0, rx, sdspi_pkg::ST_OK, sdspi_pkg::CT_NONE);
        eng[k].byte_count++;
        if (eng[k].byte_count >= NBYTES) begin
          eng[k].phase = sdspi_pkg::PH_CRC;
          eng[k].byte_count = 0;
        end
      end
      sdspi_pkg::PH_CRC, sdspi_pkg::PH_WCRC: begin
        eng[k].byte_count++;
        if (eng[k].byte_count >= 2) begin
          if (eng[k].phase == sdspi_pkg::PH_CRC) go_release(k, sdspi_pkg::ST_OK);
          else eng[k].phase = sdspi_pkg::PH_WRESP;
        end
      end
      sdspi_pkg::PH_WGAP: eng[k].phase = sdspi_pkg::PH_WTOK;
      sdspi_pkg::PH_WTOK: begin
        eng[k].phase = sdspi_pkg::PH_WDATA;
        eng[k].byte_count = 0;
      end
      sdspi_pkg::PH_WDATA: begin
        eng[k].byte_count++;
        if (eng[k].byte_count >= NBYTES) begin
          eng[k].phase = sdspi_pkg::PH_WCRC;
          eng[k].byte_count = 0;
        end
      end
      sdspi_pkg::PH_WRESP: begin
        if ((rx & sdspi_pkg::DRESP_MASK) == sdspi_pkg::DRESP_OK) begin
          eng[k].phase = sdspi_pkg::PH_WBUSY;
          eng[k].poll_count = eng[k].cfg[sdspi_pkg::CFG_BUSY_WAIT];
        end else go_release(k, sdspi_pkg::ST_RW_ERR);
      end
      sdspi_pkg::PH_WBUSY: begin
        if (rx == sdspi_pkg::IDLE_BYTE)
          go_release(k, eng[k].poll_count ? sdspi_pkg::ST_OK : sdspi_pkg::ST_RW_ERR);
        else if (eng[k].poll_count == 0) go_release(k, sdspi_pkg::ST_RW_ERR);
        else eng[k].poll_count--;
      end
      default: eng[k].phase = sdspi_pkg::PH_IDLE;
    endcase
  endfunction

  function automatic void emit_tx(int k);
    logic [7:0] tx;
    logic cs;
    tx = sdspi_pkg::IDLE_BYTE;
    cs = 1;
    if (eng[k].cmd_active) begin
      if (eng[k].cmd_stage == 0) cs = 0;
      else if (eng[k].cmd_stage >= 2 && eng[k].cmd_stage <= 7)
        tx = 8'(eng[k].frame >> (8 * (7 - eng[k].cmd_stage)));
    end else if (eng[k].phase == sdspi_pkg::PH_DUMMY ||
                 eng[k].phase == sdspi_pkg::PH_RELEASE) begin
      cs = 0;
    end else if (eng[k].phase == sdspi_pkg::PH_WTOK) begin
      tx = sdspi_pkg::TOKEN_START;
    end else if (eng[k].phase == sdspi_pkg::PH_WDATA) begin
      tx = eng[k].store[eng[k].byte_count];
    end else if (eng[k].phase == sdspi_pkg::PH_WCRC) begin
      tx = 8'd0;
    end
    add_res(sdspi_pkg::KIND_TX, tx, cs, 8'd0, sdspi_pkg::ST_OK, sdspi_pkg::CT_NONE);
  endfunction

  function automatic void predict(int k, sdspi_pkg::in_t it);
    step_res.delete();
    if (it.cmd <= sdspi_pkg::CMD_WRITE) begin
      if (eng[k].phase != sdspi_pkg::PH_IDLE) return;
      if (it.cmd == sdspi_pkg::CMD_INIT) begin
        eng[k].phase = sdspi_pkg::PH_DUMMY;
        eng[k].byte_count = 0;
        eng[k].new_kind = sdspi_pkg::CT_NONE;
        if (eng[k].cfg[sdspi_pkg::CFG_DUMMY_CLOCK_BYTES] == 0) begin
          eng[k].phase = sdspi_pkg::PH_CMD0;
          start_cmd(k, sdspi_pkg::SD_CMD0, 32'd0, 0);
        end
      end else begin
        eng[k].addr = it.sector_address;
        if (it.cmd == sdspi_pkg::CMD_READ) begin
          eng[k].half = it.half_select;
          eng[k].phase = sdspi_pkg::PH_CMD17;
          start_cmd(k, sdspi_pkg::SD_CMD17, card_addr(k, eng[k].addr), 0);
        end else begin
          eng[k].fill = 0;
          eng[k].phase = sdspi_pkg::PH_CMD24;
          start_cmd(k, sdspi_pkg::SD_CMD24, card_addr(k, eng[k].addr), 0);
        end
      end
      emit_tx(k);
    end else if (it.cmd == sdspi_pkg::CMD_LOAD) begin
      if (eng[k].phase == sdspi_pkg::PH_IDLE) begin
        eng[k].store[eng[k].fill] = it.write_byte;
        eng[k].fill = (eng[k].fill + 1) % NBYTES;
      end
    end else if (it.cmd == sdspi_pkg::CMD_SPI) begin
      if (eng[k].phase == sdspi_pkg::PH_IDLE) return;
      if (eng[k].phase == sdspi_pkg::PH_RELEASE) begin
        eng[k].phase = sdspi_pkg::PH_IDLE;
        add_res(sdspi_pkg::KIND_DONE, 8'd0, 1'b0, 8'd0, eng[k].done_st, eng[k].card_kind);
      end else begin
        if (eng[k].cmd_active) cmd_rx(k, it.spi_rx_byte);
        else phase_rx(k, it.spi_rx_byte);
        emit_tx(k);
      end
    end
    if (step_res.size() > 0) step_res[step_res.size() - 1].last_of_run = 1'b1;
  endfunction

  function automatic void reset_engine(int k);
    eng[k].phase = sdspi_pkg::PH_IDLE;
    eng[k].byte_count = 0;
    eng[k].poll_count = 0;
    eng[k].try_count = 0;
    eng[k].card_kind = sdspi_pkg::CT_NONE;
    eng[k].ocr = '{default: 8'd0};
    eng[k].frame = '0;
    eng[k].pend_frame = '0;
    eng[k].app_pend = 0;
    eng[k].fill = 0;
    eng[k].addr = '0;
    eng[k].cmd_active = 0;
    eng[k].cmd_stage = 0;
    eng[k].new_kind = sdspi_pkg::CT_NONE;
    eng[k].done_st = sdspi_pkg::ST_OK;
    eng[k].half = 0;
    eng[k].cfg = '{10, 12000, 25000, 30000, 128000, 15};
  endfunction

  // ---------------- card responder and stimulus ----------------
  function automatic sdspi_pkg::in_t make_item(logic [2:0] c, logic [31:0] a, logic [1:0] h,
                                               logic [7:0] wb, logic [7:0] rx);
    sdspi_pkg::in_t it;
    it.cmd = c; it.sector_address = a; it.half_select = h;
    it.write_byte = wb; it.spi_rx_byte = rx;
    return it;
  endfunction

  function automatic sdspi_pkg::in_t noisy(logic [2:0] c);
    return make_item(c, $urandom, 2'($urandom), 8'($urandom), 8'($urandom));
  endfunction

  // each test segment gets a fixed share of the item budget
  function automatic void add_item(sdspi_pkg::in_t it);
    if (n_items >= seg_end) return;
    n_items++;
    pending.push_back(it);
    predict(GEN, it);
  endfunction

  function automatic logic [7:0] card_reply();
    logic [7:0] r;
    int p;
    r = 8'($urandom);
    p = $urandom_range(0, 99);
    if (eng[GEN].cmd_active) begin
      if (eng[GEN].cmd_stage < 8) return r;
      // writes are rejected so no buffer entry is ever sent unloaded
      if (eng[GEN].phase == sdspi_pkg::PH_CMD24 && !eng[GEN].app_pend)
        return (p < 15) ? sdspi_pkg::IDLE_BYTE : 8'h04;
      if (p < 15) return sdspi_pkg::IDLE_BYTE;
      if (p < 20) return r;
      if (eng[GEN].app_pend) return (p < 85) ? 8'h01 : 8'h00;
      case (eng[GEN].phase)
        sdspi_pkg::PH_CMD0: return 8'h01;
        sdspi_pkg::PH_CMD8, sdspi_pkg::PH_PROBE: return (p < 60) ? 8'h01 : 8'h05;
        sdspi_pkg::PH_A41V2, sdspi_pkg::PH_V1LOOP: return (p < 60) ? 8'h00 : 8'h01;
        default: return 8'h00;
      endcase
    end
    case (eng[GEN].phase)
      sdspi_pkg::PH_R7: begin
        if (eng[GEN].byte_count == 2 && p < 90) return sdspi_pkg::VHS_ECHO;
        if (eng[GEN].byte_count == 3 && p < 90) return sdspi_pkg::CHECK_ECHO;
        return r;
      end
      sdspi_pkg::PH_TOKEN:
        return (p < 30) ? sdspi_pkg::IDLE_BYTE : (p < 95) ? sdspi_pkg::TOKEN_START : r;
      sdspi_pkg::PH_WRESP: return (p < 85) ? {r[7:5], 5'h05} : r;
      sdspi_pkg::PH_WBUSY: return (p < 40) ? 8'h00 : (p < 90) ? sdspi_pkg::IDLE_BYTE : r;
      default: return r;
    endcase
  endfunction

  // issue one request and answer as the card until the engine is idle again or the segment is full
  function automatic void run_request(sdspi_pkg::in_t req);
    add_item(req);
    while (eng[GEN].phase != sdspi_pkg::PH_IDLE && n_items < seg_end) begin
      if ($urandom_range(0, 99) < 2) add_item(noisy(3'($urandom_range(0, 3))));
      add_item(make_item(sdspi_pkg::CMD_SPI, $urandom, 2'($urandom), 8'($urandom),
                         card_reply()));
    end
  endfunction

  function automatic void random_traffic(int n_req);
    int p;
    for (int i = 0; i < n_req; i++) begin
      if (n_items >= seg_end) break;
      p = $urandom_range(0, 99);
      if (p < 25) run_request(noisy(sdspi_pkg::CMD_INIT));
      else if (p < 55) run_request(noisy(sdspi_pkg::CMD_READ));
      else if (p < 75) run_request(noisy(sdspi_pkg::CMD_WRITE));
      else if (p < 85) begin
        repeat ($urandom_range(1, 40)) add_item(noisy(sdspi_pkg::CMD_LOAD));
      end else add_item(noisy(3'($urandom_range(4, 7))));
    end
  endfunction

  task automatic drain();
    while (pending.size() > 0 || in_valid || expected_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_regs(int unsigned v0, int unsigned v1, int unsigned v2,
                            int unsigned v3, int unsigned v4, int unsigned v5);
    int unsigned vals[6];
    vals = '{v0, v1, v2, v3, v4, v5};
    for (int i = 0; i < 6; i++) begin
      @(posedge clk);
      cfg_write <= 1;
      cfg_index <= IW'(i);
      cfg_data <= DW'(vals[i]);
      eng[GEN].cfg[i] = vals[i];
      eng[CHK].cfg[i] = vals[i];
    end
    @(posedge clk);
    cfg_write <= 0;
  endtask

  initial begin
    reset_engine(GEN);
    reset_engine(CHK);
    repeat (9) @(posedge clk);
    rst <= 0;

    // directed: load part of the sector buffer, idle noise, then each request type
    seg_end = n_items + 40;
    for (int i = 0; i < 8; i++)
      add_item(make_item(sdspi_pkg::CMD_LOAD, '0, '0,
                         (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : 8'($urandom), '0));
    add_item(make_item(sdspi_pkg::CMD_SPI, '1, 2'd3, 8'hFF, 8'hFF));
    add_item(make_item(3'd5, '0, '0, '0, '0));
    add_item(make_item(3'd6, '1, '1, '1, '1));
    add_item(make_item(3'd7, '0, '0, '0, '0));
    run_request(make_item(sdspi_pkg::CMD_INIT, '0, '0, '0, '0));
    run_request(make_item(sdspi_pkg::CMD_READ, 32'h0000_0000, 2'd0, '0, '0));
    run_request(make_item(sdspi_pkg::CMD_READ, 32'hFFFF_FFFF, 2'd1, '0, '0));
    run_request(make_item(sdspi_pkg::CMD_READ, 32'h8000_0001, 2'd2, '0, '0));
    run_request(make_item(sdspi_pkg::CMD_READ, 32'h7FFF_FFFE, 2'd3, '0, '0));
    run_request(make_item(sdspi_pkg::CMD_WRITE, 32'hFFFF_FFFF, '0, '0, '0));
    random_traffic(12);
    drain();

    write_regs(0, 1, 65535, 0, 0, 0);
    send_idle = 47;
    recv_idle = 23;
    seg_end = n_items + 20;
    random_traffic(15);
    drain();

    write_regs(255, 65535, 1, 1, 262143, 255);
    seg_end = n_items + 20;
    random_traffic(15);
    drain();

    write_regs(3, 0, 4, 8, 3, 1);
    send_idle = 0;
    recv_idle = 0;
    hold_at = n_out + 5;
    seg_end = n_items + 20;
    random_traffic(20);
    drain();

    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  // ---------------- driver ----------------
  always @(posedge clk) begin : drive
    bit fire;
    fire = in_valid && in_ready;
    if (rst) begin
      in_valid <= 0;
    end else begin
      if (fire) begin
        predict(CHK, in_data);
        foreach (step_res[i]) expected_q.push_back(step_res[i]);
      end
      if (fire || !in_valid) begin
        if (pending.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
          in_data <= pending.pop_front();
          in_valid <= 1;
        end else begin
          in_valid <= 0;
        end
      end
    end
  end

  // ---------------- monitor ----------------
  always @(posedge clk) begin : watch
    sdspi_pkg::out_t exp_r;
    if (rst) begin
      out_ready <= 0;
    end else begin
      if (out_valid && out_ready) begin
        n_out++;
        if (expected_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected transaction: %p", out_data);
        end else begin
          exp_r = expected_q.pop_front();
          if (out_data !== exp_r) begin
            errors++;
            if (errors <= 10) $display("mismatch: expected %p actual %p", exp_r, out_data);
          end
        end
      end
      if (!held && n_out >= hold_at) begin
        held = 1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle);
      end
    end
  end

  // ---------------- watchdog ----------------
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) stall <= 0;
    else stall <= stall + 1;
    if (stall >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

endmodule
